### rtl/primality_trial_division_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trial-division primality block
// Shared wrappers around concurrent assertions clocked on clk.
// ----------------------------------------------------------------------------
`ifndef PRIMALITY_TRIAL_DIVISION_ASSERT_SVH
`define PRIMALITY_TRIAL_DIVISION_ASSERT_SVH

// Check a property at every rising edge outside reset
`define PTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising edge, reset included
`define PTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared widths, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  // Width of the tested number
  localparam int NUMBER_WIDTH = 32;
  // Stream data widths, padded to whole bytes
  localparam int S_TDATA_W    = ((NUMBER_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W    = 8;
  // Bit-serial divider iteration counter
  localparam int CNT_W        = $clog2(NUMBER_WIDTH);

  typedef logic [NUMBER_WIDTH-1:0] num_t;

  // First odd trial divisor and the divisor increment
  localparam num_t FIRST_DIV  = num_t'(3);
  localparam num_t DIV_STEP   = num_t'(2);
  localparam num_t SMALL_PRIME = num_t'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIVIDE,
    ST_TEST,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture number, reset divisor
    logic div_start;  // start a division of number by divisor
    logic div_step;   // one restoring division step
    logic next_div;   // advance to the next odd divisor
    logic ans_wr;     // write the answer register
    logic ans_val;    // answer to write
    logic out_load;   // move the answer to the output register
  } ptd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic trivial;        // number decided without trial division
    logic trivial_prime;  // that decision, when trivial
    logic div_last;       // current step is the last of the division
    logic keep_going;     // divisor <= quotient
    logic rem_zero;       // remainder is zero
  } ptd_stat_t;

endpackage

`default_nettype wire

### rtl/ptd_datapath.sv
// ----------------------------------------------------------------------------
// ptd_datapath
// Number and divisor registers, bit-serial restoring divider, answer and
// output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_datapath (
  input  logic                               clk,
  input  logic [ptd_pkg::NUMBER_WIDTH-1:0]   number,
  input  ptd_pkg::ptd_cmd_t                  cmd,
  output ptd_pkg::ptd_stat_t                 stat,
  output logic                               is_prime
);
  import ptd_pkg::*;

  num_t             num;
  num_t             divisor;
  num_t             rem;
  num_t             quo;
  logic [CNT_W-1:0] cnt;
  logic             ans;

  logic [NUMBER_WIDTH:0] trial;
  logic [NUMBER_WIDTH:0] diff;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder and try subtracting
  assign trial = {rem, quo[NUMBER_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  // Hold the number and walk the odd divisors
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num     <= number;
      divisor <= FIRST_DIV;
    end else if (cmd.next_div) begin
      divisor <= divisor + DIV_STEP;
    end
  end

  // Restoring division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      quo <= num;
      cnt <= CNT_W'(NUMBER_WIDTH - 1);
    end else if (cmd.div_step) begin
      rem <= fits ? diff[NUMBER_WIDTH-1:0] : trial[NUMBER_WIDTH-1:0];
      quo <= {quo[NUMBER_WIDTH-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Answer and output registers
  always_ff @(posedge clk) begin
    if (cmd.ans_wr) begin
      ans <= cmd.ans_val;
    end
    if (cmd.out_load) begin
      is_prime <= ans;
    end
  end

  // Status: negatives, zero, one and evens need no division; two is prime
  always_comb begin
    stat.trivial       = num[NUMBER_WIDTH-1] | (num[NUMBER_WIDTH-1:1] == '0) | ~num[0];
    stat.trivial_prime = (num == SMALL_PRIME);
    stat.div_last      = (cnt == '0);
    stat.keep_going    = (divisor <= quo);
    stat.rem_zero      = (rem == '0);
  end

endmodule

`default_nettype wire

### rtl/ptd_ctrl.sv
// ----------------------------------------------------------------------------
// ptd_ctrl
// Sequencer for the trial-division loop and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  ptd_pkg::ptd_stat_t  stat,
  output ptd_pkg::ptd_cmd_t   cmd
);
  import ptd_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   slot_free;

  assign slot_free = ~out_valid | m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = out_valid;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on load, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (stat.trivial) begin
          cmd.ans_wr  = 1'b1;
          cmd.ans_val = stat.trivial_prime;
          state_next  = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (!stat.keep_going) begin
          // divisor squared exceeds the number: no factor found
          cmd.ans_wr  = 1'b1;
          cmd.ans_val = 1'b1;
          state_next  = ST_FINISH;
        end else if (stat.rem_zero) begin
          cmd.ans_wr  = 1'b1;
          cmd.ans_val = 1'b0;
          state_next  = ST_FINISH;
        end else begin
          cmd.next_div  = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/primality_trial_division.sv
// ----------------------------------------------------------------------------
// primality_trial_division
// Trial-division primality test of one signed integer per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the number to test; m_* returns one beat with is_prime.
//   Negative values, zero, one and even values other than two are decided
//   without division. Odd values are divided by 3, 5, 7, ... with a
//   bit-serial restoring divider: each trial divisor takes NUMBER_WIDTH
//   divide steps and one test step. A large 32-bit prime needs about
//   23170 divisors.
//   One number is worked on at a time; s_tready is high only while idle.
//   A finished result sits in the output register, so a new number is
//   taken while m_tvalid waits on m_tready. If that register is still full
//   when the next result is done, the sequencer holds until it is taken.
//   Reset (rst, synchronous) returns the sequencer to idle and drops
//   m_tvalid; no state is kept between numbers.
// ----------------------------------------------------------------------------
`default_nettype none

module primality_trial_division (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ptd_pkg::S_TDATA_W-1:0]    s_tdata,   // [NUMBER_WIDTH-1:0] number
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ptd_pkg::M_TDATA_W-1:0]    m_tdata    // [0] is_prime, rest zero
);
  import ptd_pkg::*;

  ptd_cmd_t  cmd;
  ptd_stat_t stat;
  logic      is_prime;

  // Sequencer
  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Divider and registers
  ptd_datapath u_datapath (
    .clk      (clk),
    .number   (s_tdata[NUMBER_WIDTH-1:0]),
    .cmd      (cmd),
    .stat     (stat),
    .is_prime (is_prime)
  );

  // Pack the result beat
  assign m_tdata = {{(M_TDATA_W - 1){1'b0}}, is_prime};

endmodule

`default_nettype wire

### rtl/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks on the primality block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "primality_trial_division_assert.svh"

module ptd_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [ptd_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [ptd_pkg::M_TDATA_W-1:0]    m_tdata
);
  import ptd_pkg::*;

  // Reset leaves the block idle with no beat pending
  `PTD_ASSERT_ALWAYS(a_reset_idle, rst |=> (s_tready && !m_tvalid), "not idle after reset")

  // A stalled result beat holds
  `PTD_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result beat changed while stalled")

  // One number at a time: input closes after a beat is taken
  `PTD_ASSERT(a_one_item, (s_tvalid && s_tready) |=> !s_tready, "second number taken while busy")

  // A negative number taken while no result beat is pending is answered not prime
  `PTD_ASSERT(a_negative, (s_tvalid && s_tready && !m_tvalid && s_tdata[NUMBER_WIDTH-1]) |=> ##2 (m_tvalid && !m_tdata[0]), "negative number not rejected in time")

endmodule

bind primality_trial_division ptd_checker u_ptd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
